@@ hw/rtl/ws2812_serpentine_pixel_encoder_assert.svh @@
// Assertion macros for the WS2812 pixel encoder port checker.
// Included by file name only; depends on nothing else.
`ifndef WS2812_SERPENTINE_PIXEL_ENCODER_ASSERT_SVH
`define WS2812_SERPENTINE_PIXEL_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define WSENC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wsenc check failed");

// Next-cycle implication, disabled while reset is low
`define WSENC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wsenc check failed");

`endif

@@ hw/rtl/wsenc_pkg.sv @@
// Shared constants and types for the WS2812 serpentine pixel encoder.
// Used by the top level and by its port checker; no dependencies.
`timescale 1ns / 1ps

package wsenc_pkg;

    // Panel geometry
    localparam int PANEL_COLUMNS = 32;
    localparam int CHAIN_ROWS    = 4;
    localparam int CHAIN_COUNT   = 5;
    localparam int PANEL_ROWS    = CHAIN_ROWS * CHAIN_COUNT;

    // Field widths
    localparam int X_W     = 5;
    localparam int Y_W     = 5;
    localparam int COLOR_W = 8;
    localparam int CHAN_W  = 3;
    localparam int LED_W   = 7;
    localparam int POS_W   = 5;
    localparam int TICK_W  = 15;
    localparam int GRB_W   = 3 * COLOR_W;

    // Stream and register port widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    // Position of the final pulse of a pixel
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(GRB_W - 1);

    // Output tdata bit offsets
    localparam int M_POS_LSB = CHAN_W + LED_W;
    localparam int M_HI_LSB  = M_POS_LSB + POS_W + 1;
    localparam int M_LO_LSB  = M_HI_LSB + TICK_W;

    // Register map, indexed by paddr[3:2]
    typedef enum logic [1:0] {
        CFG_ZERO_HIGH = 2'd0,
        CFG_ZERO_LOW  = 2'd1,
        CFG_ONE_HIGH  = 2'd2,
        CFG_ONE_LOW   = 2'd3
    } cfg_idx_t;

    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 15'd8;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 15'd17;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 15'd16;
    localparam logic [TICK_W-1:0] ONE_LOW_RST   = 15'd9;

endpackage

@@ hw/rtl/ws2812_serpentine_pixel_encoder.sv @@
// WS2812 serpentine pixel encoder: top level with register file and pulse stream.
// Depends on wsenc_pkg.
`timescale 1ns / 1ps
//
// Usage
//   Input stream (s_*): one pixel per transfer, x, y and red/green/blue bytes.
//   Output stream (m_*): WS2812 bit pulses, green MSB first through blue LSB,
//   each with its chain number, serpentine LED index and high/low tick counts.
//   tlast marks the 24th pulse of a pixel. A row at or past the panel height
//   yields one pulse with tuser set, tlast set and all data zero.
//   APB port: four 15-bit tick registers at byte addresses 0, 4, 8, 12.
// Pulse flow
//   A pixel transfer loads the pixel stage; its first pulse then moves to
//   the output register and m_tvalid once that register is free. A pixel
//   gives 24 pulses (one for an out-of-range row); one pulse leaves per
//   cycle through the output register while m_tready is high. The next pixel
//   is taken in the same cycle its predecessor's last pulse loads, so pixels stream with no gap.
// Reset and stalls
//   Reset empties both stages and loads the default tick counts.
//   When m_tready is low the pulse holds; the held pixel then blocks s_tready.

module ws2812_serpentine_pixel_encoder
    import wsenc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // pixel stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // pixel_x, pixel_y, red, green, blue, pad
    // pulse stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // out_channel, led_index, bit_position,
                                             // data_bit, high_ticks, low_ticks, pad
    output logic                  m_tlast,   // last_pulse
    output logic                  m_tuser,   // out_of_range
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    localparam int TAB_DEPTH = 2 ** X_W;

    // Tick registers
    logic [TICK_W-1:0] zero_high_reg, zero_low_reg, one_high_reg, one_low_reg;
    cfg_idx_t          cfg_idx;
    logic              cfg_wr;

    // Input fields
    logic [X_W-1:0]     in_x;
    logic [Y_W-1:0]     in_y;
    logic [COLOR_W-1:0] in_r, in_g, in_b;

    // Constant mapping tables
    logic [CHAN_W-1:0] chan_tab [TAB_DEPTH];
    logic [LED_W-1:0]  base_tab [TAB_DEPTH];
    logic              odd_tab  [TAB_DEPTH];
    logic [LED_W-1:0]  col_tab  [TAB_DEPTH];
    logic [LED_W-1:0]  mir_tab  [TAB_DEPTH];

    // Pixel stage
    logic              pix_valid_reg;
    logic [CHAN_W-1:0] pix_chan_reg;
    logic [LED_W-1:0]  pix_led_reg;
    logic [GRB_W-1:0]  pix_grb_reg;
    logic              pix_oor_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CHAN_W-1:0] chan_next;
    logic [LED_W-1:0]  led_next;
    logic              oor_next;

    // Output stage
    logic              out_valid_reg;
    logic [CHAN_W-1:0] out_chan_reg;
    logic [LED_W-1:0]  out_led_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_bit_reg;
    logic [TICK_W-1:0] out_hi_reg, out_lo_reg;
    logic              out_last_reg, out_oor_reg;

    logic s_xfer, out_free, load, pix_done, cur_bit;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = cfg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write the addressed tick register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_high_reg <= ZERO_HIGH_RST;
            zero_low_reg  <= ZERO_LOW_RST;
            one_high_reg  <= ONE_HIGH_RST;
            one_low_reg   <= ONE_LOW_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_ZERO_HIGH: zero_high_reg <= pwdata[TICK_W-1:0];
                CFG_ZERO_LOW:  zero_low_reg  <= pwdata[TICK_W-1:0];
                CFG_ONE_HIGH:  one_high_reg  <= pwdata[TICK_W-1:0];
                CFG_ONE_LOW:   one_low_reg   <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            CFG_ZERO_HIGH: prdata[TICK_W-1:0] = zero_high_reg;
            CFG_ZERO_LOW:  prdata[TICK_W-1:0] = zero_low_reg;
            CFG_ONE_HIGH:  prdata[TICK_W-1:0] = one_high_reg;
            CFG_ONE_LOW:   prdata[TICK_W-1:0] = one_low_reg;
            default:       prdata = '0;
        endcase
    end

    // ---------------- pixel mapping ----------------
    assign in_x = s_tdata[X_W-1:0];
    assign in_y = s_tdata[X_W +: Y_W];
    assign in_r = s_tdata[X_W + Y_W +: COLOR_W];
    assign in_g = s_tdata[X_W + Y_W + COLOR_W +: COLOR_W];
    assign in_b = s_tdata[X_W + Y_W + 2 * COLOR_W +: COLOR_W];

    // Build row and column tables at elaboration, one entry per coordinate value
    for (genvar gi = 0; gi < TAB_DEPTH; gi++) begin : g_tab
        localparam int ChanI = gi / CHAIN_ROWS;
        localparam int RowI  = gi % CHAIN_ROWS;
        localparam int BaseI = (RowI * PANEL_COLUMNS) % (2 ** LED_W);
        localparam int ColI  = gi % PANEL_COLUMNS;
        localparam int MirI  = (PANEL_COLUMNS - 1 - ColI) % (2 ** LED_W);
        assign chan_tab[gi] = CHAN_W'(ChanI);
        assign base_tab[gi] = LED_W'(BaseI);
        assign odd_tab[gi]  = RowI[0];
        assign col_tab[gi]  = LED_W'(ColI);
        assign mir_tab[gi]  = LED_W'(MirI);
    end

    // Odd local rows run mirrored; index wraps at the field width
    assign oor_next  = (32'(in_y) >= PANEL_ROWS);
    assign chan_next = chan_tab[in_y];
    assign led_next  = base_tab[in_y] + (odd_tab[in_y] ? mir_tab[in_x] : col_tab[in_x]);

    // ---------------- handshake ----------------
    assign out_free = !out_valid_reg || m_tready;
    assign load     = pix_valid_reg && out_free;
    assign pix_done = load && (pix_oor_reg || pos_reg == POS_LAST);
    assign s_tready = !pix_valid_reg || pix_done;
    assign s_xfer   = s_tvalid && s_tready;
    assign cur_bit  = pix_grb_reg[GRB_W-1];

    // Hold the pixel until its last pulse moves to the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            pix_valid_reg <= 1'b1;
        end else if (pix_done) begin
            pix_valid_reg <= 1'b0;
        end
    end

    // Capture pixel, then shift color bits out MSB first
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pix_chan_reg <= chan_next;
            pix_led_reg  <= led_next;
            pix_grb_reg  <= {in_g, in_r, in_b};
            pix_oor_reg  <= oor_next;
            pos_reg      <= '0;
        end else if (load) begin
            pix_grb_reg  <= {pix_grb_reg[GRB_W-2:0], 1'b0};
            pos_reg      <= pos_reg + 1'b1;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load one pulse; an out-of-range row gives a single zero pulse
    always_ff @(posedge aclk) begin
        if (load) begin
            if (pix_oor_reg) begin
                out_chan_reg <= '0;
                out_led_reg  <= '0;
                out_pos_reg  <= '0;
                out_bit_reg  <= 1'b0;
                out_hi_reg   <= '0;
                out_lo_reg   <= '0;
                out_last_reg <= 1'b1;
                out_oor_reg  <= 1'b1;
            end else begin
                out_chan_reg <= pix_chan_reg;
                out_led_reg  <= pix_led_reg;
                out_pos_reg  <= pos_reg;
                out_bit_reg  <= cur_bit;
                out_hi_reg   <= cur_bit ? one_high_reg : zero_high_reg;
                out_lo_reg   <= cur_bit ? one_low_reg  : zero_low_reg;
                out_last_reg <= (pos_reg == POS_LAST);
                out_oor_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_oor_reg;
    assign m_tdata  = {2'b00, out_lo_reg, out_hi_reg, out_bit_reg, out_pos_reg,
                       out_led_reg, out_chan_reg};

endmodule

@@ hw/rtl/wsenc_checker.sv @@
// Port checker for the WS2812 serpentine pixel encoder, bound to the top level.
// Depends on wsenc_pkg and ws2812_serpentine_pixel_encoder_assert.svh.
`timescale 1ns / 1ps
`include "ws2812_serpentine_pixel_encoder_assert.svh"

module wsenc_checker
    import wsenc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic                 m_tuser
);

    logic                 m_xfer;
    logic [POS_W-1:0]     m_pos;
    logic [CHAN_W+LED_W-1:0] m_where;

    assign m_xfer  = m_tvalid && m_tready;
    assign m_pos   = m_tdata[M_POS_LSB +: POS_W];
    assign m_where = m_tdata[CHAN_W+LED_W-1:0];

    // Hold a stalled pulse
    `WSENC_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // Flagged row: one final, all-zero pulse
    `WSENC_ASSERT_IMP(a_oor_single, aclk, aresetn, m_tvalid && m_tuser,
        m_tlast && (m_tdata == '0))

    // The final pulse of a pixel is exactly bit 23
    `WSENC_ASSERT_IMP(a_last_pos, aclk, aresetn, m_tvalid && !m_tuser,
        (m_pos == POS_LAST) == m_tlast)

    // Within a pixel the position advances by one and the LED stays put
    `WSENC_ASSERT_NXT(a_pos_step, aclk, aresetn, m_xfer && !m_tlast,
        !m_tvalid || ((m_pos == $past(m_pos) + 1'b1) && (m_where == $past(m_where))))

endmodule

bind ws2812_serpentine_pixel_encoder wsenc_checker u_wsenc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

@@ sim/ws2812_serpentine_pixel_encoder_tb.sv @@
// Self-checking testbench for ws2812_serpentine_pixel_encoder: drives pixels,
// programs the tick registers over APB and checks every pulse against a local model.
// Depends on wsenc_pkg and the encoder top level only.
`timescale 1ns / 1ps

module ws2812_serpentine_pixel_encoder_tb;
    import wsenc_pkg::*;

    typedef struct packed {
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [LED_W-1:0]  led;
        logic [POS_W-1:0]  pos;
        logic              data_bit;
        logic [TICK_W-1:0] hi;
        logic [TICK_W-1:0] lo;
        logic              last;
        logic              oor;
    } pulse_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // pixel_x, pixel_y, red, green, blue, pad
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // out_channel, led_index, bit_position,
                                     // data_bit, high_ticks, low_ticks, pad
    logic                 m_tlast;   // last_pulse
    logic                 m_tuser;   // out_of_range
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Local copy of the tick registers and the pulses still owed by the block
    logic [TICK_W-1:0] tick_regs [4];
    pulse_t            expected_pulses [$];
    int                mismatches;
    int                send_idle_pct;
    int                recv_idle_pct;

    ws2812_serpentine_pixel_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // Stall the pulse stream at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Queue the 24 GRB pulses of a pixel, or the single flagged one for a row off the panel
    function automatic void encode_pixel(pixel_t p);
        pulse_t            e;
        logic [GRB_W-1:0]  grb;
        int                row;
        int                col;
        e = '0;
        if (p.y >= PANEL_ROWS) begin
            e.last = 1'b1;
            e.oor  = 1'b1;
            expected_pulses.push_back(e);
            return;
        end
        row    = p.y % CHAIN_ROWS;
        col    = p.x % PANEL_COLUMNS;
        e.chan = CHAN_W'(p.y / CHAIN_ROWS);
        // odd rows of a chain run mirrored
        e.led  = LED_W'(row * PANEL_COLUMNS + ((row % 2) ? PANEL_COLUMNS - 1 - col : col));
        grb    = {p.green, p.red, p.blue};
        for (int k = 0; k < GRB_W; k++) begin
            e.pos      = POS_W'(k);
            e.data_bit = grb[GRB_W-1-k];
            e.hi       = e.data_bit ? tick_regs[CFG_ONE_HIGH] : tick_regs[CFG_ZERO_HIGH];
            e.lo       = e.data_bit ? tick_regs[CFG_ONE_LOW] : tick_regs[CFG_ZERO_LOW];
            e.last     = (k == GRB_W - 1);
            expected_pulses.push_back(e);
        end
    endfunction

    // Compare each pulse transfer with the oldest expectation
    always @(posedge aclk) begin : check_pulses
        pulse_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pulses.size() == 0) begin
                $display("%0t: unexpected pulse, actual tdata %h tlast %b tuser %b",
                         $time, m_tdata, m_tlast, m_tuser);
                mismatches++;
            end else begin
                want = expected_pulses.pop_front();
                check_field("out_channel", 32'(want.chan), 32'(m_tdata[CHAN_W-1:0]));
                check_field("led_index", 32'(want.led), 32'(m_tdata[M_POS_LSB-1:CHAN_W]));
                check_field("bit_position", 32'(want.pos),
                            32'(m_tdata[M_HI_LSB-2:M_POS_LSB]));
                check_field("data_bit", 32'(want.data_bit), 32'(m_tdata[M_HI_LSB-1]));
                check_field("high_ticks", 32'(want.hi), 32'(m_tdata[M_LO_LSB-1:M_HI_LSB]));
                check_field("low_ticks", 32'(want.lo),
                            32'(m_tdata[M_LO_LSB+TICK_W-1:M_LO_LSB]));
                check_field("last_pulse", 32'(want.last), 32'(m_tlast));
                check_field("out_of_range", 32'(want.oor), 32'(m_tuser));
            end
        end
    end

    // Send one pixel after a random gap; valid stays high on return
    task automatic send_pixel(pixel_t p);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, p.blue, p.green, p.red, p.y, p.x};
        do @(posedge aclk); while (!s_tready);
        encode_pixel(p);
    endtask

    task automatic send_rgb(int x, int y, int r, int g, int b);
        pixel_t p;
        p = {X_W'(x), Y_W'(y), COLOR_W'(r), COLOR_W'(g), COLOR_W'(b)};
        send_pixel(p);
    endtask

    // Drop valid and wait until every owed pulse has left
    task automatic drain_pulses();
        s_tvalid <= 1'b0;
        while (expected_pulses.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(cfg_idx_t idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tick_regs[idx] = value[TICK_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Read a register and compare it with the local copy
    task automatic apb_check(cfg_idx_t idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("prdata", 32'(tick_regs[idx]), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write all four tick counts while idle, then read them back
    task automatic program_ticks(logic [APB_DW-1:0] zh, logic [APB_DW-1:0] zl,
                                 logic [APB_DW-1:0] oh, logic [APB_DW-1:0] ol);
        drain_pulses();
        apb_write(CFG_ZERO_HIGH, zh);
        apb_write(CFG_ZERO_LOW, zl);
        apb_write(CFG_ONE_HIGH, oh);
        apb_write(CFG_ONE_LOW, ol);
        for (int i = 0; i < 4; i++) apb_check(cfg_idx_t'(i));
    endtask

    task automatic test_reset_values();
        for (int i = 0; i < 4; i++) apb_check(cfg_idx_t'(i));
    endtask

    // Geometry corners under the default tick counts
    task automatic test_panel_corners();
        send_rgb(0, 0, 8'h00, 8'h00, 8'h00);
        send_rgb(31, 0, 8'hFF, 8'hFF, 8'hFF);
        send_rgb(0, 1, 8'hAA, 8'h55, 8'h0F);     // mirrored row, left edge
        send_rgb(31, 3, 8'h55, 8'hAA, 8'hF0);    // mirrored row, right edge
        send_rgb(5, 2, 8'h80, 8'h01, 8'h7E);
        send_rgb(17, 4, 8'h01, 8'h80, 8'hC3);    // first row of the second chain
        send_rgb(16, 7, 8'h3C, 8'hE7, 8'h18);
        send_rgb(31, 19, 8'hFE, 8'h7F, 8'h81);   // last row on the panel
        send_rgb(0, 20, 8'hFF, 8'hFF, 8'hFF);    // first row off the panel
        send_rgb(31, 31, 8'h12, 8'h34, 8'h56);   // farthest row off the panel
    endtask

    // Tick counts at their extremes, zero included, and write data wider than a register
    task automatic test_tick_extremes();
        program_ticks(32767, 32767, 32767, 32767);
        send_rgb(9, 10, 8'hA5, 8'h5A, 8'hFF);
        send_rgb(22, 13, 8'h00, 8'hFF, 8'h00);
        program_ticks(1, 1, 1, 1);
        send_rgb(3, 6, 8'hF0, 8'h0F, 8'h99);
        send_rgb(30, 25, 8'h11, 8'h22, 8'h33);
        program_ticks(0, 32767, 0, 1);
        send_rgb(12, 9, 8'hC0, 8'h03, 8'h5A);
        send_rgb(27, 15, 8'h6B, 8'hD4, 8'h2E);
        program_ticks(32'hFFFF_FFFF, 32'h5555_0002, 32'hAAAA_8003, 32'h0001_4000);
        send_rgb(14, 18, 8'h96, 8'h69, 8'hE1);
        send_rgb(1, 11, 8'h1E, 8'hB7, 8'h4D);
        program_ticks(APB_DW'(ZERO_HIGH_RST), APB_DW'(ZERO_LOW_RST),
                      APB_DW'(ONE_HIGH_RST), APB_DW'(ONE_LOW_RST));
    endtask

    function automatic logic [APB_DW-1:0] random_ticks();
        if ($urandom_range(3) == 0) return $urandom();
        return $urandom_range(32767, 1);
    endfunction

    // Random pixels in three idle modes, fresh tick counts before each
    task automatic test_random_stream(int per_phase);
        pixel_t p;
        for (int phase = 0; phase < 3; phase++) begin
            program_ticks(random_ticks(), random_ticks(), random_ticks(), random_ticks());
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 26 : 0;
            for (int n = 0; n < per_phase; n++) begin
                p.x     = X_W'($urandom());
                p.red   = COLOR_W'($urandom());
                p.green = COLOR_W'($urandom());
                p.blue  = COLOR_W'($urandom());
                // keep most rows on the panel
                p.y = ($urandom_range(99) < 15) ? Y_W'($urandom_range(31, PANEL_ROWS))
                                                : Y_W'($urandom_range(PANEL_ROWS - 1));
                send_pixel(p);
            end
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        tick_regs[CFG_ZERO_HIGH] = ZERO_HIGH_RST;
        tick_regs[CFG_ZERO_LOW]  = ZERO_LOW_RST;
        tick_regs[CFG_ONE_HIGH]  = ONE_HIGH_RST;
        tick_regs[CFG_ONE_LOW]   = ONE_LOW_RST;
        mismatches    = 0;
        send_idle_pct = 26;
        recv_idle_pct = 46;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_panel_corners();
        test_tick_extremes();
        test_random_stream(150);

        // Let the last pulse settle before judging
        drain_pulses();
        repeat (30) @(posedge aclk);
        if (mismatches == 0)
            $display("ws2812_serpentine_pixel_encoder: match");
        else
            $display("ws2812_serpentine_pixel_encoder: mismatch");
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial begin
        #2000000;
        $display("ws2812_serpentine_pixel_encoder: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/wsenc_pkg.sv
hw/rtl/ws2812_serpentine_pixel_encoder.sv
hw/rtl/wsenc_checker.sv
sim/ws2812_serpentine_pixel_encoder_tb.sv
